// ===== rtl/bbs_pkg.sv =====
// bbs_pkg: shared types and constants for the step length estimator
// no dependencies
package bbs_pkg;

	localparam int unsigned GRAD_FLOOR_RESET = 43;

	typedef struct packed {
		logic [63:0] pos_sum;
		logic [63:0] grad_sum;
		logic        sat_seen;
	} bbs_job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} bbs_state_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV,
		F_SQ,
		F_SUM,
		F_ACC,
		F_PUSH
	} bbs_fstate_t;

	// 64-bit add with saturation, carry out in msb
	function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			return {1'b1, {64{1'b1}}};
		end
		return s;
	endfunction

endpackage

// ===== rtl/bbs_gdiv.sv =====
// bbs_gdiv: iterative divider, (|diff| << 16) / weight for one gradient axis
// depends on bbs_pkg
module bbs_gdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] mag,
	input  logic [31:0] weight,
	output logic        done,
	output logic [48:0] quot
);
	import bbs_pkg::*;

	logic [48:0] dividend_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;

	assign trial = {rem_q, dividend_q[48]} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {mag, 16'h0000};
			rem_q      <= '0;
			div_q      <= (weight < 32'h0001_0000) ? 32'h0001_0000 : weight;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				dividend_q <= {dividend_q[47:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], dividend_q[48]};
				dividend_q <= {dividend_q[47:0], 1'b0};
			end
		end
	end

	assign quot = dividend_q;
endmodule

// ===== rtl/bbs_front.sv =====
// bbs_front: accepts nodes, squares position and preconditioned gradient changes,
// accumulates sums; depends on bbs_pkg and bbs_gdiv
module bbs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [23:0]      nx,
	input  logic [23:0]      ny,
	input  logic [23:0]      cx,
	input  logic [23:0]      cy,
	input  logic [31:0]      ngx,
	input  logic [31:0]      ngy,
	input  logic [31:0]      cgx,
	input  logic [31:0]      cgy,
	input  logic [31:0]      weight,
	input  logic             last,
	output logic             job_valid,
	input  logic             job_ready,
	output bbs_pkg::bbs_job_t job
);
	import bbs_pkg::*;

	bbs_fstate_t st_q, st_d;

	logic [63:0] pos_q, grad_q, pterm_q;
	logic        sat_q, last_q;
	logic [32:0] magx, magy;
	logic        dx_done, dy_done;
	logic [48:0] qx, qy;
	logic [23:0] dx, dy;
	logic [48:0] crx, cry;
	logic [63:0] llx_q, lly_q;
	logic [30:0] crx_q, cry_q;
	logic [63:0] gxx_q, gyy_q;
	logic [64:0] t_sum, p_new, g_new;
	logic        start;

	function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	assign magx  = absdiff(ngx, cgx);
	assign magy  = absdiff(ngy, cgy);
	assign dx    = (nx >= cx) ? nx - cx : cx - nx;
	assign dy    = (ny >= cy) ? ny - cy : cy - ny;
	assign start = in_valid && in_ready;
	assign in_ready = (st_q == F_IDLE);

	bbs_gdiv u_divx (.clk, .arst_n, .start, .mag(magx), .weight, .done(dx_done), .quot(qx));
	bbs_gdiv u_divy (.clk, .arst_n, .start, .mag(magy), .weight, .done(dy_done), .quot(qy));

	// cross terms of the split square, only their low 31 bits reach the result
	assign crx   = qx[31:0] * qx[48:32];
	assign cry   = qy[31:0] * qy[48:32];
	assign t_sum = sat_add64(gxx_q, gyy_q);
	assign p_new = sat_add64(pos_q, pterm_q);
	assign g_new = sat_add64(grad_q, t_sum[63:0]);

	always_comb begin
		st_d = st_q;
		case (st_q)
			F_IDLE: if (start) st_d = F_DIV;
			F_DIV:  if (dx_done) st_d = F_SQ;
			F_SQ:   st_d = F_SUM;
			F_SUM:  st_d = F_ACC;
			F_ACC:  st_d = last_q ? F_PUSH : F_IDLE;
			F_PUSH: if (job_ready) st_d = F_IDLE;
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			pos_q  <= '0;
			grad_q <= '0;
			sat_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == F_ACC) begin
				pos_q  <= p_new[63:0];
				grad_q <= g_new[63:0];
				sat_q  <= sat_q | p_new[64] | t_sum[64] | g_new[64];
			end else if (st_q == F_PUSH && job_ready) begin
				pos_q  <= '0;
				grad_q <= '0;
				sat_q  <= 1'b0;
			end
		end
	end

	// position term and last flag on accept; squares of quotients kept modulo 2^64, built from 32x32 and 32x17 products
	always_ff @(posedge clk) begin
		if (start) begin
			pterm_q <= 64'({24'h0, dx} * {24'h0, dx}) + 64'({24'h0, dy} * {24'h0, dy});
			last_q  <= last;
		end
		if (st_q == F_SQ) begin
			llx_q <= qx[31:0] * qx[31:0];
			lly_q <= qy[31:0] * qy[31:0];
			crx_q <= crx[30:0];
			cry_q <= cry[30:0];
		end
		if (st_q == F_SUM) begin
			gxx_q <= llx_q + {crx_q, 33'h0};
			gyy_q <= lly_q + {cry_q, 33'h0};
		end
	end

	assign job_valid    = (st_q == F_PUSH);
	assign job.pos_sum  = pos_q;
	assign job.grad_sum = grad_q;
	assign job.sat_seen = sat_q;
	logic unused_q;
	assign unused_q = dy_done;
endmodule

// ===== rtl/bbs_back.sv =====
// bbs_back: final ratio, long division then integer square root, output register
// depends on bbs_pkg
module bbs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       grad_floor,
	input  logic              job_valid,
	output logic              job_ready,
	input  bbs_pkg::bbs_job_t job,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       est,
	output logic              sat
);
	import bbs_pkg::*;

	bbs_state_t st_q, st_d;
	logic [63:0] p_q, d_q, r_q, q_q, x_q, res_q, bit_q;
	logic [6:0]  cnt_q;
	logic        sat_q;
	logic        jsat_q;
	logic [64:0] den;
	logic [64:0] rsh;
	logic        ge;
	logic [63:0] in_bit;
	logic [64:0] sqt;

	assign den = sat_add64(job.grad_sum, {48'h0, grad_floor});
	assign job_ready = (st_q == ST_IDLE);
	assign in_bit = (cnt_q >= 7'd48) ? {63'h0, p_q[63]} : 64'h0;
	assign rsh = {r_q, in_bit[0]};
	assign ge  = rsh[64] || (rsh[63:0] >= d_q);
	assign sqt = {1'b0, x_q} - {1'b0, res_q + bit_q};

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (job_valid) st_d = ST_DIV;
			ST_DIV:  if (d_q == 64'h0 || cnt_q == 7'd0) st_d = (d_q == 64'h0) ? ST_OUT : ST_SQRT;
			ST_SQRT: if (bit_q == 64'h0) st_d = ST_OUT;
			ST_OUT:  if (out_ready || !out_valid) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (st_q == ST_OUT && (out_ready || !out_valid)) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				p_q   <= job.pos_sum;
				d_q   <= den[63:0];
				r_q   <= '0;
				q_q   <= '0;
				cnt_q <= 7'd111;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				// ratio at least 2^16 saturates
				sat_q <= 1'b0;
				if (den[63:0] == 64'h0) begin
					sat_q <= job.pos_sum != 64'h0;
				end else if (den[63:48] == 16'h0 && job.pos_sum >= {den[47:0], 16'h0}) begin
					sat_q <= 1'b1;
					d_q   <= 64'h0;
				end
				jsat_q <= job.sat_seen;
			end
			ST_DIV: begin
				if (cnt_q >= 7'd48) p_q <= {p_q[62:0], 1'b0};
				r_q   <= ge ? 64'(rsh - {1'b0, d_q}) : rsh[63:0];
				q_q   <= {q_q[62:0], ge};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) x_q <= {q_q[62:0], ge};
			end
			ST_SQRT: begin
				if (bit_q > x_q && res_q == 64'h0) begin
					bit_q <= bit_q >> 2;
				end else if (bit_q != 64'h0) begin
					if (!sqt[64]) begin
						x_q   <= sqt[63:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			ST_OUT: begin
				if (out_ready || !out_valid) begin
					est <= sat_q ? 32'hFFFF_FFFF : res_q[31:0];
					sat <= jsat_q | sat_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/bb_step_length_estimate.sv =====
// bb_step_length_estimate: barzilai-borwein step length over a node stream
// order: a node runs the 49-step gradient dividers, then F_SQ, F_SUM and F_ACC fold it into
// the sums; a last node's result then runs the back end's 112-step division, 32-step square
// root and output register (sooner when the ratio saturates); the front takes a new node only
// once the last is folded in, and a pass ending while the back end is busy stalls
// reset: arst_n clears sums, flags and handshake state; grad_floor returns to 43
// depends on bbs_pkg, bbs_front, bbs_back
module bb_step_length_estimate (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: next_probe_x, next_probe_y, cur_probe_x, cur_probe_y, next_grad_x,
	// next_grad_y, cur_grad_x, cur_grad_y, node_weight (lowest first)
	input  logic [255:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: step_estimate
	output logic [31:0]  m_axis_tdata,
	// tuser: saturated
	output logic         m_axis_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import bbs_pkg::*;

	logic [15:0] grad_floor_q;
	logic        job_valid, job_ready;
	bbs_job_t    job;

	// register 0 at byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'h0, grad_floor_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_floor_q <= 16'(GRAD_FLOOR_RESET);
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			grad_floor_q <= pwdata[15:0];
		end
	end

	bbs_front u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.nx (s_axis_tdata[23:0]),
		.ny (s_axis_tdata[47:24]),
		.cx (s_axis_tdata[71:48]),
		.cy (s_axis_tdata[95:72]),
		.ngx (s_axis_tdata[127:96]),
		.ngy (s_axis_tdata[159:128]),
		.cgx (s_axis_tdata[191:160]),
		.cgy (s_axis_tdata[223:192]),
		.weight (s_axis_tdata[255:224]),
		.last (s_axis_tlast),
		.job_valid, .job_ready, .job
	);

	bbs_back u_back (
		.clk, .arst_n,
		.grad_floor (grad_floor_q),
		.job_valid, .job_ready, .job,
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.est (m_axis_tdata),
		.sat (m_axis_tuser)
	);

	logic unused_q;
	assign unused_q = ^{pwdata[31:16]};
endmodule

// ===== tb/bb_step_length_estimate_tb.sv =====
// bb_step_length_estimate_tb: self-checking bench for the step length estimator
// holds its own bit-exact predictor of the sums and ratio; drives the node stream and apb port
// depends on bbs_pkg and bb_step_length_estimate
module bb_step_length_estimate_tb;
	import bbs_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE_CYCLES = 250;   // a node plus the ratio back end
	localparam logic [1:0] ADDR_GRAD_FLOOR = 2'd0;

	// one placement node as the stream carries it
	typedef struct {
		logic [23:0] nx, ny, cx, cy;
		logic [31:0] ngx, ngy, cgx, cgy;
		logic [31:0] weight;
		logic        last;
	} node_t;

	typedef struct {
		logic [31:0] step;
		logic        sat;
	} step_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         psel, penable, pwrite;
	logic [1:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	bb_step_length_estimate dut (.*);

	// predictor state, a mirror of the block's accumulators
	logic [63:0] acc_pos;
	logic [63:0] acc_grad;
	logic        acc_sat;
	logic [15:0] floor_reg;
	step_t       pending_steps[$];
	int          errors;
	int          cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		$display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
		errors++;
	endtask

	// saturating 64-bit add
	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
			inout logic flag);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			flag = 1'b1;
			return {64{1'b1}};
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r, b, x;
		r = 0;
		x = v;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// magnitude of a preconditioned gradient difference, Q.16
	function automatic logic [63:0] scaled_grad(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] w);
		longint d;
		logic [63:0] mag, wq;
		d = longint'($signed(a)) - longint'($signed(b));
		mag = d < 0 ? -d : d;
		wq = w < 32'h10000 ? 64'h10000 : {32'd0, w};
		return (mag << 16) / wq;
	endfunction

	// fold one node into the sums; on a last node queue the expected ratio
	task automatic predict_step(input node_t n);
		logic [63:0] dx, dy, gx, gy, term, den;
		logic [111:0] num;
		logic sat, dsat;
		step_t r;
		sat = 1'b0;
		dsat = 1'b0;
		dx = n.nx >= n.cx ? n.nx - n.cx : n.cx - n.nx;
		dy = n.ny >= n.cy ? n.ny - n.cy : n.cy - n.ny;
		acc_pos = add_sat(acc_pos, dx * dx + dy * dy, sat);
		gx = scaled_grad(n.ngx, n.cgx, n.weight);
		gy = scaled_grad(n.ngy, n.cgy, n.weight);
		term = add_sat(gx * gx, gy * gy, sat);
		acc_grad = add_sat(acc_grad, term, sat);
		if (sat) acc_sat = 1'b1;
		if (!n.last) return;
		den = add_sat(acc_grad, {48'd0, floor_reg}, dsat);
		r.sat = acc_sat;
		if (den == 0) begin
			// zero denominator: saturate unless positions did not move
			r.step = acc_pos != 0 ? 32'hFFFFFFFF : 32'd0;
			if (acc_pos != 0) r.sat = 1'b1;
		end else if (den < (64'd1 << 48) && acc_pos >= (den << 16)) begin
			r.step = 32'hFFFFFFFF;
			r.sat = 1'b1;
		end else begin
			num = {acc_pos, 48'd0};
			r.step = root_floor(64'(num / den));
		end
		pending_steps.push_back(r);
		acc_pos = 0;
		acc_grad = 0;
		acc_sat = 1'b0;
	endtask

	// receiver: stall pattern changes in stretches, some with no stalls at all
	int rx_mode, rx_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode <= 0;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_left <= $urandom_range(5, 400);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				2: m_axis_tready <= ($urandom_range(0, 9) == 0);
				default: m_axis_tready <= (rx_left % 7) > 2;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_steps.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, 64'(m_axis_tdata));
			end else begin
				step_t e;
				e = pending_steps.pop_front();
				if (m_axis_tdata !== e.step)
					report_mismatch("step_estimate", 64'(e.step), 64'(m_axis_tdata));
				if (m_axis_tuser !== e.sat)
					report_mismatch("saturated", 64'(e.sat), 64'(m_axis_tuser));
			end
		end
	end

	// sender burst bookkeeping
	int burst_left;

	// one node transaction; valid stays up into the next call unless a gap is due
	task automatic send_node(input node_t n);
		s_axis_tvalid <= 1'b1;
		s_axis_tlast <= n.last;
		s_axis_tdata <= {n.weight, n.cgy, n.cgx, n.ngy, n.ngx, n.cy, n.cx, n.ny, n.nx};
		do @(posedge clk); while (!s_axis_tready);
		predict_step(n);
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	// hold off until every expected ratio is back, then let the back end settle
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_floor(input logic [15:0] v);
		drain_block();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_GRAD_FLOOR;
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		floor_reg = v;
	endtask

	function automatic node_t plain_node(input logic last);
		node_t n;
		n.nx = 0; n.ny = 0; n.cx = 0; n.cy = 0;
		n.ngx = 0; n.ngy = 0; n.cgx = 0; n.cgy = 0;
		n.weight = 32'h10000;
		n.last = last;
		return n;
	endfunction

	function automatic logic [31:0] rand_grad();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'(int'($urandom_range(0, 400000)) - 200000);
		endcase
	endfunction

	function automatic node_t rand_node(input logic last);
		node_t n;
		n.nx = 24'($urandom()); n.ny = 24'($urandom());
		if ($urandom_range(0, 2) == 0) begin
			n.cx = 24'($urandom()); n.cy = 24'($urandom());
		end else begin
			// small moves, the usual case inside a placement iteration
			n.cx = n.nx + 24'($urandom_range(0, 2000) - 1000);
			n.cy = n.ny + 24'($urandom_range(0, 2000) - 1000);
		end
		n.ngx = rand_grad(); n.ngy = rand_grad();
		n.cgx = rand_grad(); n.cgy = rand_grad();
		case ($urandom_range(0, 5))
			0: n.weight = $urandom_range(0, 32'hFFFF);   // below one
			1: n.weight = $urandom();
			default: n.weight = $urandom_range(32'h10000, 32'h400000);
		endcase
		n.last = last;
		return n;
	endfunction

	// extremes, weight handling and the saturation corners
	task automatic test_directed();
		node_t n;
		send_node(plain_node(1'b1));                   // nothing moved
		n = plain_node(1'b1);
		n.nx = 24'hFFFFFF; n.cy = 24'hFFFFFF;          // widest move, no gradient change
		send_node(n);
		n = plain_node(1'b0);
		n.ngx = 32'h7FFFFFFF; n.cgx = 32'h80000000;    // largest gradient change
		n.ngy = 32'h80000000; n.cgy = 32'h7FFFFFFF;
		n.weight = 32'h0;                              // weight below one taken as one
		send_node(n);
		n.last = 1'b1; n.nx = 24'h1;                   // grad sum saturates
		send_node(n);
		n = plain_node(1'b1);
		n.nx = 24'h100; n.ngx = 32'h1; n.weight = 32'hFFFFFFFF;
		send_node(n);
		n = plain_node(1'b0);
		n.nx = 24'h123456; n.ngx = 32'h00010000; n.weight = 32'hFFFF;
		send_node(n);
		n.weight = 32'h10000; n.last = 1'b1;
		send_node(n);
		n = plain_node(1'b1);
		n.nx = 24'h000010; n.cx = 24'h000020; n.ngy = 32'hFFFF0000; n.cgy = 32'h00020000;
		n.weight = 32'h00030000;
		send_node(n);
		for (int i = 0; i < 6; i++) send_node(rand_node(i == 5));
	endtask

	// floor of zero gives the zero denominator cases
	task automatic test_zero_floor();
		node_t n;
		write_floor(16'd0);
		send_node(plain_node(1'b1));
		n = plain_node(1'b1);
		n.nx = 24'h5; send_node(n);
		n = plain_node(1'b1);
		n.ngx = 32'h5; send_node(n);
		send_node(rand_node(1'b1));
	endtask

	// random passes of varied length under the current floor
	task automatic test_random_passes(input int count);
		int len;
		while (count > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
			for (int i = 0; i < len && count > 0; i++, count--)
				send_node(rand_node(i == len - 1 || count == 1));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		acc_pos = 0; acc_grad = 0; acc_sat = 1'b0;
		floor_reg = 16'(GRAD_FLOOR_RESET);
		errors = 0;
		cycles = 0;
		burst_left = 4;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_passes(450);
		drain_block();                  // full pause with nothing in flight
		test_zero_floor();
		test_random_passes(400);
		write_floor(16'hFFFF);
		test_directed();
		test_random_passes(450);
		write_floor(16'($urandom()));
		test_random_passes(450);
		write_floor(16'd43);
		test_random_passes(100);

		drain_block();
		if (pending_steps.size() != 0)
			report_mismatch("results missing", 64'd0, 64'(pending_steps.size()));
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
